/* rtl/ocfo_pkg.sv */
package ocfo_pkg;

    localparam int SW       = 16;
    localparam int PN_DEPTH = 64;
    localparam int PNW      = 6;
    localparam int ACC_W    = 58;
    localparam int EN_W     = 38;
    localparam int WW       = 128;

    localparam logic CFG_USED  = 1'b0;
    localparam logic CFG_RANGE = 1'b1;

    localparam logic REQ_PN  = 1'b0;
    localparam logic REQ_BIN = 1'b1;

    localparam logic [6:0] USED_RST  = 7'd52;
    localparam logic [4:0] RANGE_RST = 5'd8;

    typedef struct packed {
        logic wr_pn;
        logic wr_bin;
        logic rd_vld;
        logic rd_energy;
        logic clr_energy;
        logic clr_corr;
        logic den_start;
        logic ratio_start;
        logic out_load;
        logic metric_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic energy_zero;
    } dp_stat_t;

endpackage

/* rtl/ocfo_datapath.sv */
module ocfo_datapath #(
    parameter int FFT_SIZE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ocfo_pkg::dp_cmd_t                 cmd,
    input  logic [$clog2(FFT_SIZE)-1:0]       bin_addr,
    input  logic [$clog2(FFT_SIZE)-1:0]       rd_idx,
    input  logic [ocfo_pkg::PNW-1:0]          rd_pn,
    input  logic [ocfo_pkg::PNW-1:0]          pn_addr,
    input  logic [31:0]                       pn_word,
    input  logic [31:0]                       x1_word,
    input  logic [31:0]                       x2_word,
    output ocfo_pkg::dp_stat_t                stat,
    output logic [15:0]                       metric
);
    localparam int ACC_W = ocfo_pkg::ACC_W;
    localparam int EN_W  = ocfo_pkg::EN_W;
    localparam int WW    = ocfo_pkg::WW;
    localparam int DEN_SAT_SH = 29;
    localparam int DEN_DIV_SH = 28;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_MUL  = 2'd1;
    localparam logic [1:0] SQ_CHK  = 2'd2;
    localparam logic [1:0] SQ_DIV  = 2'd3;

    localparam logic [1:0] P_DEN = 2'd0;
    localparam logic [1:0] P_AR  = 2'd1;
    localparam logic [1:0] P_AI  = 2'd2;

    localparam logic [1:0] ISS_DONE = 2'd3;
    localparam logic [1:0] ISS_LAST = 2'd2;

    logic [31:0] mem1 [FFT_SIZE];
    logic [31:0] mem2 [FFT_SIZE];
    logic [31:0] pnm  [ocfo_pkg::PN_DEPTH];

    logic [31:0] s1_reg, s2_reg, pn0_reg, pn1_reg, pn2_reg;
    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic        e0_reg, e1_reg, e2_reg, e3_reg;

    logic signed [15:0] a, b, c, d, nr, ni;
    logic signed [31:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [32:0] pr_reg, pi_reg, en_reg;
    logic signed [48:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic        [31:0] en3_reg;

    logic signed [ACC_W-1:0] ar_reg, ai_reg;
    logic        [EN_W-1:0]  energy_reg;

    logic [1:0]    seq_reg, pass_reg, iss_reg, pp_sh_reg;
    logic          pp_v_reg, pp_last_reg;
    logic [63:0]   sq_op_reg, pp_reg;
    logic [WW-1:0] den_reg, num_reg, rem_reg, dsh_reg, pp_ext;
    logic [15:0]   q_reg, out_metric_reg;
    logic [3:0]    dcnt_reg;

    logic [31:0] ma, mb;
    logic [63:0] ar_ext, ai_ext, ar_abs, ai_abs;
    logic        sat, ge;

    always_ff @(posedge aclk) begin
        if (cmd.wr_bin) begin
            mem1[bin_addr] <= x1_word;
            mem2[bin_addr] <= x2_word;
        end
        if (cmd.wr_pn) begin
            pnm[pn_addr] <= pn_word;
        end
        s1_reg  <= mem1[rd_idx];
        s2_reg  <= mem2[rd_idx];
        pn0_reg <= pnm[rd_pn];
    end

    assign a  = s1_reg[15:0];
    assign b  = s1_reg[31:16];
    assign c  = s2_reg[15:0];
    assign d  = s2_reg[31:16];
    assign nr = pn2_reg[15:0];
    assign ni = pn2_reg[31:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= cmd.rd_vld;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg  <= cmd.rd_energy;
        e1_reg  <= e0_reg;
        e2_reg  <= e1_reg;
        e3_reg  <= e2_reg;
        pn1_reg <= pn0_reg;
        pn2_reg <= pn1_reg;
        ac_reg  <= a * c;
        bd_reg  <= b * d;
        ad_reg  <= a * d;
        bc_reg  <= b * c;
        cc_reg  <= c * c;
        dd_reg  <= d * d;
        pr_reg  <= 33'(ac_reg) + 33'(bd_reg);
        pi_reg  <= 33'(ad_reg) - 33'(bc_reg);
        en_reg  <= 33'(cc_reg) + 33'(dd_reg);
        prr_reg <= pr_reg * nr;
        pii_reg <= pi_reg * ni;
        pri_reg <= pr_reg * ni;
        pir_reg <= pi_reg * nr;
        en3_reg <= en_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_energy) begin
            energy_reg <= '0;
        end else if (v3_reg && e3_reg) begin
            energy_reg <= energy_reg + EN_W'(en3_reg);
        end
        if (cmd.clr_corr) begin
            ar_reg <= '0;
            ai_reg <= '0;
        end else if (v3_reg && !e3_reg) begin
            ar_reg <= ar_reg + ACC_W'(prr_reg) - ACC_W'(pii_reg);
            ai_reg <= ai_reg + ACC_W'(pri_reg) + ACC_W'(pir_reg);
        end
    end

    assign ar_ext = 64'(ar_reg);
    assign ai_ext = 64'(ai_reg);
    assign ar_abs = ar_reg[ACC_W-1] ? (64'd0 - ar_ext) : ar_ext;
    assign ai_abs = ai_reg[ACC_W-1] ? (64'd0 - ai_ext) : ai_ext;

    // squares in three partial products: lo*lo, 2*lo*hi, hi*hi
    always_comb begin
        case (iss_reg)
            2'd0: begin
                ma = sq_op_reg[31:0];
                mb = sq_op_reg[31:0];
            end
            2'd1: begin
                ma = sq_op_reg[31:0];
                mb = sq_op_reg[63:32];
            end
            default: begin
                ma = sq_op_reg[63:32];
                mb = sq_op_reg[63:32];
            end
        endcase
    end

    always_comb begin
        case (pp_sh_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1:    pp_ext = {64'd0, pp_reg} << 33;
            default: pp_ext = {64'd0, pp_reg} << 64;
        endcase
    end

    assign sat = num_reg >= (den_reg << DEN_SAT_SH);
    assign ge  = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg  <= SQ_IDLE;
            pass_reg <= P_DEN;
            iss_reg  <= ISS_DONE;
            pp_v_reg <= 1'b0;
        end else begin
            case (seq_reg)
                SQ_IDLE: begin
                    pp_v_reg <= 1'b0;
                    if (cmd.den_start) begin
                        seq_reg  <= SQ_MUL;
                        pass_reg <= P_DEN;
                        iss_reg  <= 2'd0;
                    end else if (cmd.ratio_start) begin
                        seq_reg  <= SQ_MUL;
                        pass_reg <= P_AR;
                        iss_reg  <= 2'd0;
                    end
                end
                SQ_MUL: begin
                    if (iss_reg != ISS_DONE) begin
                        pp_v_reg <= 1'b1;
                        iss_reg  <= iss_reg + 2'd1;
                    end else begin
                        pp_v_reg <= 1'b0;
                    end
                    if (pp_v_reg && pp_last_reg) begin
                        case (pass_reg)
                            P_DEN: seq_reg <= SQ_IDLE;
                            P_AR: begin
                                pass_reg <= P_AI;
                                iss_reg  <= 2'd0;
                            end
                            default: seq_reg <= SQ_CHK;
                        endcase
                    end
                end
                SQ_CHK: begin
                    seq_reg <= sat ? SQ_IDLE : SQ_DIV;
                end
                SQ_DIV: begin
                    if (dcnt_reg == 4'd0) begin
                        seq_reg <= SQ_IDLE;
                    end
                end
                default: seq_reg <= SQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (seq_reg)
            SQ_IDLE: begin
                if (cmd.den_start) begin
                    sq_op_reg <= 64'(energy_reg);
                    den_reg   <= '0;
                end else if (cmd.ratio_start) begin
                    sq_op_reg <= ar_abs;
                    num_reg   <= '0;
                end
            end
            SQ_MUL: begin
                pp_reg      <= ma * mb;
                pp_sh_reg   <= iss_reg;
                pp_last_reg <= (iss_reg == ISS_LAST);
                if (pp_v_reg) begin
                    if (pass_reg == P_DEN) begin
                        den_reg <= den_reg + pp_ext;
                    end else begin
                        num_reg <= num_reg + pp_ext;
                    end
                    if (pp_last_reg && pass_reg == P_AR) begin
                        sq_op_reg <= ai_abs;
                    end
                end
            end
            SQ_CHK: begin
                if (sat) begin
                    q_reg <= 16'hFFFF;
                end else begin
                    q_reg    <= '0;
                    rem_reg  <= num_reg;
                    dsh_reg  <= den_reg << DEN_DIV_SH;
                    dcnt_reg <= 4'd15;
                end
            end
            SQ_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg    <= {q_reg[14:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                dcnt_reg <= dcnt_reg - 4'd1;
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            out_metric_reg <= cmd.metric_zero ? 16'd0 : q_reg;
        end
    end

    assign stat.busy        = (seq_reg != SQ_IDLE) | v0_reg | v1_reg | v2_reg | v3_reg;
    assign stat.energy_zero = (energy_reg == '0);
    assign metric           = out_metric_reg;

endmodule

/* rtl/ocfo_ctrl.sv */
module ocfo_ctrl #(
    parameter int FFT_SIZE  = 64,
    parameter int MAX_RANGE = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [6:0]                        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [5:0]                        m_shift,
    output logic                              m_last,
    output logic                              m_zero,
    output ocfo_pkg::dp_cmd_t                 cmd,
    output logic [$clog2(FFT_SIZE)-1:0]       bin_addr,
    output logic [$clog2(FFT_SIZE)-1:0]       rd_idx,
    output logic [ocfo_pkg::PNW-1:0]          rd_pn,
    input  ocfo_pkg::dp_stat_t                stat
);
    localparam int IW = $clog2(FFT_SIZE);
    localparam int RW = $clog2(FFT_SIZE + 128) + 2;
    localparam logic [IW-1:0]        LAST_BIN = IW'(FFT_SIZE - 1);
    localparam logic signed [RW-1:0] FFT_S    = RW'(FFT_SIZE);
    localparam logic [4:0]           RMAX     = 5'(MAX_RANGE);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PREP     = 4'd1;
    localparam logic [3:0] ST_RED_E    = 4'd2;
    localparam logic [3:0] ST_RED_S    = 4'd3;
    localparam logic [3:0] ST_EN_ISS   = 4'd4;
    localparam logic [3:0] ST_EN_WAIT  = 4'd5;
    localparam logic [3:0] ST_DEN_WAIT = 4'd6;
    localparam logic [3:0] ST_SHIFT    = 4'd7;
    localparam logic [3:0] ST_CO_ISS   = 4'd8;
    localparam logic [3:0] ST_CO_WAIT  = 4'd9;
    localparam logic [3:0] ST_RAT_WAIT = 4'd10;
    localparam logic [3:0] ST_EMIT     = 4'd11;

    logic [3:0]           state_reg;
    logic [IW-1:0]        cnt_reg, e_idx_reg, sh_idx_reg, idx_reg;
    logic [6:0]           used_reg, term_reg;
    logic [4:0]           range_cfg_reg, rng_reg;
    logic signed [RW-1:0] red_reg;
    logic [5:0]           k_reg;
    logic                 zero_reg, mz_reg;
    logic                 m_valid_reg, m_last_reg, m_zero_reg;
    logic [5:0]           m_shift_reg;

    logic                 acc, red_lt, red_ge, out_free, odd_shift;
    logic [6:0]           nterm;
    logic [7:0]           used_p1;
    logic [IW:0]          idx_p2_raw, idx_p2;
    logic [IW-1:0]        idx_next, sh_idx_next;
    logic signed [RW-1:0] diff, pad;
    logic [5:0]           two_r;

    assign s_ready    = (state_reg == ST_IDLE);
    assign acc        = s_valid & s_ready;
    assign used_p1    = {1'b0, used_reg} + 8'd1;
    assign nterm      = used_p1[7:1];
    assign diff       = FFT_S - RW'(used_reg);
    assign pad        = (diff + RW'(1)) >>> 1;
    assign red_lt     = red_reg < 0;
    assign red_ge     = red_reg >= FFT_S;
    assign idx_p2_raw = {1'b0, idx_reg} + (IW+1)'(2);
    assign idx_p2     = (idx_p2_raw >= (IW+1)'(FFT_SIZE)) ?
                        idx_p2_raw - (IW+1)'(FFT_SIZE) : idx_p2_raw;
    assign idx_next   = idx_p2[IW-1:0];
    assign sh_idx_next = (sh_idx_reg == LAST_BIN) ? '0 : sh_idx_reg + IW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign two_r      = {rng_reg, 1'b0};
    assign odd_shift  = k_reg[0] ^ rng_reg[0];

    always_comb begin
        cmd             = '0;
        cmd.wr_pn       = acc & !s_req_type;
        cmd.wr_bin      = acc & s_req_type;
        cmd.clr_energy  = (state_reg == ST_PREP);
        cmd.clr_corr    = (state_reg == ST_SHIFT);
        cmd.rd_vld      = ((state_reg == ST_EN_ISS) || (state_reg == ST_CO_ISS)) &&
                          (term_reg != nterm);
        cmd.rd_energy   = (state_reg == ST_EN_ISS);
        cmd.den_start   = (state_reg == ST_EN_WAIT) && !stat.busy && !stat.energy_zero;
        cmd.ratio_start = (state_reg == ST_CO_WAIT) && !stat.busy;
        cmd.out_load    = (state_reg == ST_EMIT) && out_free;
        cmd.metric_zero = mz_reg;
    end

    assign bin_addr = cnt_reg;
    assign rd_idx   = idx_reg;
    assign rd_pn    = {term_reg[4:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= ocfo_pkg::USED_RST;
            range_cfg_reg <= ocfo_pkg::RANGE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                ocfo_pkg::CFG_USED:  used_reg      <= cfg_data;
                ocfo_pkg::CFG_RANGE: range_cfg_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc && s_req_type) begin
                        if (cnt_reg == LAST_BIN) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_PREP;
                        end else begin
                            cnt_reg <= cnt_reg + IW'(1);
                        end
                    end
                end
                ST_PREP: state_reg <= ST_RED_E;
                ST_RED_E: if (!red_lt && !red_ge) state_reg <= ST_RED_S;
                ST_RED_S: if (!red_lt && !red_ge) state_reg <= ST_EN_ISS;
                ST_EN_ISS: if (term_reg == nterm) state_reg <= ST_EN_WAIT;
                ST_EN_WAIT: begin
                    if (!stat.busy) begin
                        state_reg <= stat.energy_zero ? ST_SHIFT : ST_DEN_WAIT;
                    end
                end
                ST_DEN_WAIT: if (!stat.busy) state_reg <= ST_SHIFT;
                ST_SHIFT: begin
                    state_reg <= (zero_reg || odd_shift) ? ST_EMIT : ST_CO_ISS;
                end
                ST_CO_ISS: if (term_reg == nterm) state_reg <= ST_CO_WAIT;
                ST_CO_WAIT: if (!stat.busy) state_reg <= ST_RAT_WAIT;
                ST_RAT_WAIT: if (!stat.busy) state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= (k_reg == two_r) ? ST_IDLE : ST_SHIFT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_PREP: begin
                red_reg  <= pad;
                rng_reg  <= (range_cfg_reg > RMAX) ? RMAX : range_cfg_reg;
                term_reg <= '0;
                k_reg    <= '0;
            end
            ST_RED_E: begin
                if (red_lt) begin
                    red_reg <= red_reg + FFT_S;
                end else if (red_ge) begin
                    red_reg <= red_reg - FFT_S;
                end else begin
                    e_idx_reg <= red_reg[IW-1:0];
                    idx_reg   <= red_reg[IW-1:0];
                    red_reg   <= red_reg - RW'(rng_reg);
                end
            end
            ST_RED_S: begin
                if (red_lt) begin
                    red_reg <= red_reg + FFT_S;
                end else if (red_ge) begin
                    red_reg <= red_reg - FFT_S;
                end else begin
                    sh_idx_reg <= red_reg[IW-1:0];
                    idx_reg    <= e_idx_reg;
                end
            end
            ST_EN_ISS, ST_CO_ISS: begin
                if (term_reg != nterm) begin
                    term_reg <= term_reg + 7'd1;
                    idx_reg  <= idx_next;
                end
            end
            ST_EN_WAIT: begin
                if (!stat.busy) begin
                    zero_reg <= stat.energy_zero;
                end
            end
            ST_SHIFT: begin
                mz_reg   <= zero_reg || odd_shift;
                term_reg <= '0;
                idx_reg  <= sh_idx_reg;
            end
            ST_RAT_WAIT: mz_reg <= 1'b0;
            ST_EMIT: begin
                if (out_free) begin
                    m_shift_reg <= k_reg - {1'b0, rng_reg};
                    m_last_reg  <= (k_reg == two_r);
                    m_zero_reg  <= zero_reg;
                    k_reg       <= k_reg + 6'd1;
                    sh_idx_reg  <= sh_idx_next;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_shift = m_shift_reg;
    assign m_last  = m_last_reg;
    assign m_zero  = m_zero_reg;

endmodule

/* rtl/ofdm_integer_cfo_metric_core.sv */
// Integer carrier frequency offset metric, Schmidl-Cox.
// Input stream: s_tuser selects the item kind (0 = PN coefficient load,
// 1 = bin pair of both preambles). PN loads and bin pairs are accepted
// while the core is idle; the FFT_SIZE-th bin starts a metric run and s_tready
// drops until the run's last result has been loaded into the output register.
// A run: fold the left padding into the bin range, accumulate the
// preamble-two energy over ceil(U/2) terms and square it, then per even shift
// run the correlation pipeline, the shared squaring unit and the 16-step
// divider, and emit; odd shifts, and every shift when the energy is zero, go
// straight to the emit step with a zero metric.
// Output stream: one transfer per shift from -range to +range, tlast on the
// final one, tuser flags a zero energy. A stalled receiver holds the run in
// its emit step; one finished result waits in the output register.
// Configuration must be written only while idle; the core does not enforce it. Reset
// clears the bin count and restores used_carriers = 52, search_range = 8; stores are not cleared.
module ofdm_integer_cfo_metric_core #(
    parameter int FFT_SIZE  = 64,
    parameter int MAX_RANGE = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [6:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pn_index, pn_re, pn_im, first_re, first_im, second_re, second_im, zero fill
    input  logic [103:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // metric, shift, zero fill
    output logic [23:0]  m_tdata,
    output logic         m_tlast,
    // zero_denominator
    output logic [0:0]   m_tuser
);
    localparam int IW = $clog2(FFT_SIZE);

    ocfo_pkg::dp_cmd_t  cmd;
    ocfo_pkg::dp_stat_t stat;
    logic [IW-1:0]      bin_addr, rd_idx;
    logic [5:0]         rd_pn, m_shift;
    logic [15:0]        metric;
    logic               m_zero;

    ocfo_ctrl #(
        .FFT_SIZE  (FFT_SIZE),
        .MAX_RANGE (MAX_RANGE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_req_type (s_tuser[0]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_shift    (m_shift),
        .m_last     (m_tlast),
        .m_zero     (m_zero),
        .cmd        (cmd),
        .bin_addr   (bin_addr),
        .rd_idx     (rd_idx),
        .rd_pn      (rd_pn),
        .stat       (stat)
    );

    ocfo_datapath #(
        .FFT_SIZE (FFT_SIZE)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .bin_addr (bin_addr),
        .rd_idx   (rd_idx),
        .rd_pn    (rd_pn),
        .pn_addr  (s_tdata[5:0]),
        .pn_word  (s_tdata[37:6]),
        .x1_word  (s_tdata[69:38]),
        .x2_word  (s_tdata[101:70]),
        .stat     (stat),
        .metric   (metric)
    );

    assign m_tdata = {2'b00, m_shift, metric};
    assign m_tuser = m_zero;

endmodule
